// ===== rtl/rimc_pkg.sv =====
package rimc_pkg;

  // Default sizing of the block.
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int ROW_BITS_DEF    = 63;

  // Fixed field widths.
  localparam int ROW_W   = 63;
  localparam int ADDR_W  = 12;
  localparam int COUNT_W = 32;
  localparam int STEP_W  = 64;
  localparam int ACC_W   = 128;

  localparam logic [ROW_W-1:0]   MIN_RESET    = {ROW_W{1'b1}};
  localparam logic [ROW_W-1:0]   NARROW_LIMIT = ROW_W'(64'd2147483647);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_STEP  = 2'd2;

  // Inner map forms. Code 3 behaves as no inner map.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SLICE = 2'd1;
  localparam logic [1:0] MODE_TABLE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_IDX = 2'd1;
  localparam logic [1:0] STAT_OVF = 2'd2;

  // The slice product takes four 32x32 partial products, plus a final step to
  // drain the product register into the accumulator.
  localparam logic [2:0] MUL_PARTS = 3'd4;
  localparam logic [2:0] MUL_LAST  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;     // input transaction accepted this cycle
    logic       pp_en;    // form one partial product
    logic [1:0] pp_sel;   // which partial product
    logic       acc_en;   // add the registered partial product
    logic       sum_en;   // combine start with the product
    logic       fin_en;   // update run state and load the output register
  } cmd_t;

endpackage

// ===== rtl/rimc_ctrl.sv =====
module rimc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  input  logic [1:0]      mode,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output rimc_pkg::cmd_t  cmd
);
  import rimc_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid && in_kind) begin
          if (mode == MODE_SLICE) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
      end
      ST_MUL: begin
        cmd.pp_en  = (cnt_r < MUL_PARTS);
        cmd.pp_sel = cnt_r[1:0];
        cmd.acc_en = (cnt_r != 3'd0);
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
      end
      ST_FINISH: begin
        cmd.fin_en = out_free;
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (cnt_r <= MUL_LAST))
    else $error("multiply step counter out of range");

  a_slice_path: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && in_kind && mode == MODE_SLICE) |=> (state_r == ST_MUL))
    else $error("slice map transaction did not start the multiply");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && !in_kind) |=> (state_r == ST_IDLE))
    else $error("table load left the idle state");

  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_en |=> out_valid_r)
    else $error("finished result not presented");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_en || cmd.sum_en || cmd.fin_en) |-> !cmd.take)
    else $error("transaction accepted while an item is in flight");
`endif

endmodule

// ===== rtl/rimc_dp.sv =====
module rimc_dp #(
  parameter int TABLE_DEPTH = rimc_pkg::TABLE_DEPTH_DEF,
  parameter int ROW_BITS    = rimc_pkg::ROW_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rimc_pkg::cmd_t               cmd,
  input  logic [1:0]                   mode,
  input  logic [rimc_pkg::ROW_W-1:0]   start,
  input  logic [rimc_pkg::STEP_W-1:0]  step,
  input  logic                         in_kind,
  input  logic [rimc_pkg::ADDR_W-1:0]  in_table_addr,
  input  logic [rimc_pkg::ROW_W-1:0]   in_table_value,
  input  logic [rimc_pkg::ROW_W-1:0]   in_b_row,
  input  logic                         in_last,
  output logic [rimc_pkg::ROW_W-1:0]   out_a_row,
  output logic [rimc_pkg::ROW_W-1:0]   out_run_min,
  output logic [rimc_pkg::ROW_W-1:0]   out_run_max,
  output logic [rimc_pkg::COUNT_W-1:0] out_run_count,
  output logic                         out_fits_narrow,
  output logic [1:0]                   out_status,
  output logic                         out_last_out
);
  import rimc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [63:0]      DEPTH64  = 64'(TABLE_DEPTH);
  localparam logic [ROW_W-1:0] ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - ROW_BITS);

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  logic [ROW_BITS-1:0] mem [TABLE_DEPTH];
  logic [ROW_BITS-1:0] rd_data_r;

  logic [ROW_W-1:0]   b_in;
  logic [63:0]        addr64;
  logic [ROW_W-1:0]   b_r;
  logic               last_r;
  logic               neg_r;
  logic [STEP_W-1:0]  mag_r;
  logic [63:0]        pp_r;
  logic [1:0]         pp_sh_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   sum_r;

  logic [31:0]        mul_a, mul_b;
  logic [1:0]         pp_sh;
  logic [ACC_W-1:0]   addend;

  logic [ROW_W-1:0]   min_r, max_r;
  logic [COUNT_W-1:0] count_r;
  logic [ROW_W-1:0]   row, min_n, max_n;
  logic [COUNT_W-1:0] count_n;
  logic [1:0]         status;

  assign b_in   = in_b_row & ROW_MASK;
  assign addr64 = 64'(in_table_addr);

  // Table: one write port for loads, one registered read at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.take && !in_kind && (addr64 < DEPTH64)) begin
      mem[addr64[AW-1:0]] <= in_table_value[ROW_BITS-1:0];
    end
    if (cmd.take) begin
      rd_data_r <= mem[b_in[AW-1:0]];
    end
  end

  // Partial product operand selection.
  always_comb begin
    case (cmd.pp_sel)
      2'd0: begin
        mul_a = b_r[31:0];
        mul_b = mag_r[31:0];
        pp_sh = SH_0;
      end
      2'd1: begin
        mul_a = b_r[31:0];
        mul_b = mag_r[63:32];
        pp_sh = SH_32;
      end
      2'd2: begin
        mul_a = {1'b0, b_r[62:32]};
        mul_b = mag_r[31:0];
        pp_sh = SH_32;
      end
      default: begin
        mul_a = {1'b0, b_r[62:32]};
        mul_b = mag_r[63:32];
        pp_sh = SH_64;
      end
    endcase
  end

  always_comb begin
    case (pp_sh_r)
      SH_0:    addend = {64'b0, pp_r};
      SH_32:   addend = {32'b0, pp_r, 32'b0};
      default: addend = {pp_r, 64'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      b_r    <= b_in;
      last_r <= in_last;
      neg_r  <= step[STEP_W-1];
      mag_r  <= step[STEP_W-1] ? (STEP_W'(0) - step) : step;
      acc_r  <= '0;
    end else begin
      if (cmd.pp_en) begin
        pp_r    <= 64'(mul_a) * 64'(mul_b);
        pp_sh_r <= pp_sh;
      end
      if (cmd.acc_en) begin
        acc_r <= acc_r + addend;
      end
    end
    // A negative result wraps to a value with its top bit set, which the
    // range check below then treats as an overflow.
    if (cmd.sum_en) begin
      sum_r <= neg_r ? (ACC_W'(start) - acc_r) : (ACC_W'(start) + acc_r);
    end
  end

  // Composition, status and run statistics.
  always_comb begin
    row    = '0;
    status = STAT_OK;
    case (mode)
      MODE_SLICE: begin
        if (|sum_r[ACC_W-1:ROW_BITS]) begin
          status = STAT_OVF;
        end else begin
          row = sum_r[ROW_W-1:0];
        end
      end
      MODE_TABLE: begin
        if (64'(b_r) >= DEPTH64) begin
          status = STAT_IDX;
        end else begin
          row = ROW_W'(rd_data_r);
        end
      end
      default: begin
        row = b_r;
      end
    endcase

    min_n   = min_r;
    max_n   = max_r;
    count_n = count_r;
    if (status == STAT_OK) begin
      if (row < min_r) min_n = row;
      if (row > max_r) max_n = row;
      if (count_r != COUNT_MAX) count_n = count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= MIN_RESET;
      max_r   <= '0;
      count_r <= '0;
    end else if (cmd.fin_en) begin
      if (last_r) begin
        min_r   <= MIN_RESET;
        max_r   <= '0;
        count_r <= '0;
      end else begin
        min_r   <= min_n;
        max_r   <= max_n;
        count_r <= count_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      out_a_row       <= row;
      out_run_min     <= min_n;
      out_run_max     <= max_n;
      out_run_count   <= count_n;
      out_fits_narrow <= (max_n <= NARROW_LIMIT) && (count_n <= COUNT_W'(NARROW_LIMIT));
      out_status      <= status;
      out_last_out    <= last_r;
    end
  end

endmodule

// ===== rtl/row_index_map_composer.sv =====
// A map transaction with no inner map or with the index table goes from acceptance
// straight to the finish state, which loads the output register; with the slice it
// first walks the 32x32 multiplier over four parts and then combines the product
// with start. Table loads are taken one per cycle while no map is in flight; a map
// transaction stalls input until its result is loaded. Reset (rst_n, synchronous)
// clears the controller, run statistics and configuration registers, not the table.
module row_index_map_composer #(
  parameter int TABLE_DEPTH = rimc_pkg::TABLE_DEPTH_DEF,
  parameter int ROW_BITS    = rimc_pkg::ROW_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [rimc_pkg::STEP_W-1:0]  cfg_data,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [rimc_pkg::ADDR_W-1:0]  in_table_addr,
  input  logic [rimc_pkg::ROW_W-1:0]   in_table_value,
  input  logic [rimc_pkg::ROW_W-1:0]   in_b_row,
  input  logic                         in_last,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rimc_pkg::ROW_W-1:0]   out_a_row,
  output logic [rimc_pkg::ROW_W-1:0]   out_run_min,
  output logic [rimc_pkg::ROW_W-1:0]   out_run_max,
  output logic [rimc_pkg::COUNT_W-1:0] out_run_count,
  output logic                         out_fits_narrow,
  output logic [1:0]                   out_status,
  output logic                         out_last_out
);
  import rimc_pkg::*;

  // Configuration registers. The port is always ready; the user must see that
  // configuration only changes while no transaction is in flight (not enforced).
  logic [1:0]        mode_r;
  logic [ROW_W-1:0]  start_r;
  logic [STEP_W-1:0] step_r;
  cmd_t              cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      start_r <= '0;
      step_r  <= STEP_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[1:0];
        CFG_START: start_r <= cfg_data[ROW_W-1:0];
        CFG_STEP:  step_r  <= cfg_data;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // The controller sequences each map transaction; table loads are written
  // straight into the table in the accepting cycle.
  rimc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .mode      (mode_r),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the table, the slice multiplier, the run statistics and
  // the output register, which frees the pipeline while a result waits.
  rimc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ROW_BITS    (ROW_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .mode            (mode_r),
    .start           (start_r),
    .step            (step_r),
    .in_kind         (in_kind),
    .in_table_addr   (in_table_addr),
    .in_table_value  (in_table_value),
    .in_b_row        (in_b_row),
    .in_last         (in_last),
    .out_a_row       (out_a_row),
    .out_run_min     (out_run_min),
    .out_run_max     (out_run_max),
    .out_run_count   (out_run_count),
    .out_fits_narrow (out_fits_narrow),
    .out_status      (out_status),
    .out_last_out    (out_last_out)
  );

endmodule

// ===== bench/row_index_map_composer_tb.sv =====
module row_index_map_composer_tb;
  import rimc_pkg::*;

  // Codes that the package does not name.
  localparam logic       KIND_LOAD  = 1'b0;
  localparam logic       KIND_MAP   = 1'b1;
  localparam logic [1:0] MODE_ALIAS = 2'd3;  // unused form code, acts as no inner map
  localparam logic [1:0] CFG_UNUSED = 2'd3;  // register index with nothing behind it

  localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

  // The slowest transaction (slice form) runs the multiply, sum and finish steps
  // after acceptance; this many quiet cycles leave the block idle.
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_TIME = 5_000_000;
  localparam int MAX_REPORTS   = 10;

  // One result transaction, in port order.
  typedef struct packed {
    logic [ROW_W-1:0]   a_row;
    logic [ROW_W-1:0]   run_min;
    logic [ROW_W-1:0]   run_max;
    logic [COUNT_W-1:0] run_count;
    logic               fits_narrow;
    logic [1:0]         status;
    logic               last_out;
  } row_result_t;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index       = CFG_MODE;
  logic [STEP_W-1:0]   cfg_data        = '0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic                in_kind         = KIND_LOAD;
  logic [ADDR_W-1:0]   in_table_addr   = '0;
  logic [ROW_W-1:0]    in_table_value  = '0;
  logic [ROW_W-1:0]    in_b_row        = '0;
  logic                in_last         = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [ROW_W-1:0]    out_a_row;
  logic [ROW_W-1:0]    out_run_min;
  logic [ROW_W-1:0]    out_run_max;
  logic [COUNT_W-1:0]  out_run_count;
  logic                out_fits_narrow;
  logic [1:0]          out_status;
  logic                out_last_out;

  row_index_map_composer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_table_addr   (in_table_addr),
    .in_table_value  (in_table_value),
    .in_b_row        (in_b_row),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_a_row       (out_a_row),
    .out_run_min     (out_run_min),
    .out_run_max     (out_run_max),
    .out_run_count   (out_run_count),
    .out_fits_narrow (out_fits_narrow),
    .out_status      (out_status),
    .out_last_out    (out_last_out)
  );

  // Shadow copy of the block: configuration, index table and run statistics.
  // Reset happens once, so the initial values here are the reset values.
  logic [1:0]         cur_mode  = MODE_NONE;
  logic [ROW_W-1:0]   cur_start = '0;
  logic [STEP_W-1:0]  cur_step  = 64'd1;
  logic [ROW_W-1:0]   inner_rows [TABLE_DEPTH_DEF];
  logic               loaded     [TABLE_DEPTH_DEF];
  logic [ADDR_W-1:0]  loaded_addrs [$];
  logic [ROW_W-1:0]   run_lo    = MIN_RESET;
  logic [ROW_W-1:0]   run_hi    = '0;
  logic [COUNT_W-1:0] run_n     = '0;

  // Composed rows that the block still owes us, oldest first.
  row_result_t awaited_rows [$];

  // Idling mix of the current phase, in percent of cycles.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  int mismatches  = 0;
  int loads_sent  = 0;
  int maps_sent   = 0;
  int ok_seen     = 0;
  int idx_seen    = 0;
  int ovf_seen    = 0;
  int runs_closed = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (loaded[i]) loaded[i] = 1'b0;
  end

  // Watchdog: a hung handshake must not keep the run alive forever.
  initial begin
    #(WATCHDOG_TIME);
    $display("Watchdog expired with %0d results outstanding", awaited_rows.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver stalls at random in the proportion that the phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Apply one accepted transaction to the shadow copy. A load only fills the
  // table; a map transaction yields exactly one result, pushed to the queue.
  function automatic void predict_item(input logic kind, input logic [ADDR_W-1:0] addr,
                                       input logic [ROW_W-1:0] value,
                                       input logic [ROW_W-1:0] b, input logic last);
    row_result_t          want;
    logic [ROW_W-1:0]     row;
    logic [1:0]           st;
    logic signed [129:0]  exact;
    if (kind == KIND_LOAD) begin
      inner_rows[addr] = value;
      if (!loaded[addr]) begin
        loaded[addr] = 1'b1;
        loaded_addrs.push_back(addr);
      end
      loads_sent++;
      return;
    end
    maps_sent++;
    row = '0;
    st  = STAT_OK;
    case (cur_mode)
      MODE_SLICE: begin
        // Exact start + b * step in a width that cannot overflow; anything
        // outside the row range is reported rather than wrapped.
        exact = $signed({67'd0, cur_start}) +
                $signed({67'd0, b}) * $signed({{66{cur_step[63]}}, cur_step});
        if (exact < 0 || exact > $signed({67'd0, ROW_MAX})) st = STAT_OVF;
        else row = exact[ROW_W-1:0];
      end
      MODE_TABLE: begin
        if (b >= TABLE_DEPTH_DEF) st = STAT_IDX;
        else row = inner_rows[b[ADDR_W-1:0]];
      end
      default: row = b;  // no inner map, and the unused form code
    endcase
    // An erroneous element reports the statistics without joining them.
    if (st == STAT_OK) begin
      if (row < run_lo) run_lo = row;
      if (row > run_hi) run_hi = row;
      if (run_n != COUNT_MAX) run_n++;
    end
    want.a_row       = row;
    want.run_min     = run_lo;
    want.run_max     = run_hi;
    want.run_count   = run_n;
    want.fits_narrow = (run_hi <= NARROW_LIMIT) && ({31'd0, run_n} <= NARROW_LIMIT);
    want.status      = st;
    want.last_out    = last;
    awaited_rows.push_back(want);
    // The last element closes the run, whatever its status.
    if (last) begin
      run_lo = MIN_RESET;
      run_hi = '0;
      run_n  = '0;
    end
  endfunction

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    row_result_t got;
    row_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = '{out_a_row, out_run_min, out_run_max, out_run_count,
              out_fits_narrow, out_status, out_last_out};
      if (awaited_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected: row %h status %0d",
                   $realtime, got.a_row, got.status);
      end else begin
        want = awaited_rows.pop_front();
        case (want.status)
          STAT_OK:  ok_seen++;
          STAT_IDX: idx_seen++;
          default:  ovf_seen++;
        endcase
        if (want.last_out) runs_closed++;
        if (got.a_row !== want.a_row || got.run_min !== want.run_min ||
            got.run_max !== want.run_max || got.run_count !== want.run_count ||
            got.fits_narrow !== want.fits_narrow || got.status !== want.status ||
            got.last_out !== want.last_out) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch, expected row %h min %h max %h count %0d fits %0b st %0d last %0b",
                     $realtime, want.a_row, want.run_min, want.run_max, want.run_count,
                     want.fits_narrow, want.status, want.last_out);
            $display("%0t:           actual  row %h min %h max %h count %0d fits %0b st %0d last %0b",
                     $realtime, got.a_row, got.run_min, got.run_max, got.run_count,
                     got.fits_narrow, got.status, got.last_out);
          end
        end
      end
    end
  end

  // Row values with weight on the edges: zero, all ones, around the 32-bit
  // limit, small rows, rows of random magnitude and fully random rows.
  function automatic logic [ROW_W-1:0] pick_row();
    logic [31:0]      hi;
    logic [31:0]      lo;
    logic [ROW_W-1:0] r;
    hi = $urandom;
    lo = $urandom;
    r  = {hi[30:0], lo};
    case ($urandom_range(7))
      0:       return '0;
      1:       return ROW_MAX;
      2:       return NARROW_LIMIT + ROW_W'(lo[1:0]) - ROW_W'(1);
      3:       return ROW_W'(lo[7:0]);
      4:       return r >> hi[5:0];
      default: return r;
    endcase
  endfunction

  // Slice strides: zero, both extremes, 32-bit values, full random, and small
  // strides of either sign, which keep most products in range.
  function automatic logic [STEP_W-1:0] pick_step();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = $urandom;
    lo = $urandom;
    case ($urandom_range(7))
      0:       return '0;
      1:       return 64'h8000_0000_0000_0000;
      2:       return 64'h7FFF_FFFF_FFFF_FFFF;
      3:       return {{32{lo[31]}}, lo};
      4:       return {hi, lo};
      default: return {{61{lo[3]}}, lo[2:0]};
    endcase
  endfunction

  // Offer one transaction and hold it until the block takes it; then maybe
  // leave the input idle for a while, as the phase asks.
  task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr,
                           input logic [ROW_W-1:0] value, input logic [ROW_W-1:0] b,
                           input logic last);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_table_addr  <= addr;
    in_table_value <= value;
    in_b_row       <= b;
    in_last        <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(kind, addr, value, b, last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Fields that a transaction does not use still carry random bits.
  task automatic send_load(input logic [ADDR_W-1:0] addr, input logic [ROW_W-1:0] value);
    send_item(KIND_LOAD, addr, value, pick_row(), 1'($urandom_range(1)));
  endtask

  task automatic send_map(input logic [ROW_W-1:0] b, input logic last);
    send_item(KIND_MAP, ADDR_W'($urandom_range(4095)), pick_row(), b, last);
  endtask

  // Stop offering input and wait until the block has nothing left in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration write; only ever issued while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [STEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MODE:  cur_mode  = data[1:0];
      CFG_START: cur_start = data[ROW_W-1:0];
      CFG_STEP:  cur_step  = data;
      default:   ;  // no register here, nothing changes
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // With no inner map the outer row passes straight through. This covers the
  // row extremes, the 32-bit boundary of the narrow flag, the empty run after
  // a last element, and the unused form code behaving as no inner map.
  task automatic test_identity_map();
    send_map('0, 1'b0);
    send_map(ROW_MAX, 1'b0);
    send_map(NARROW_LIMIT, 1'b1);
    send_map(NARROW_LIMIT, 1'b0);
    send_map(NARROW_LIMIT + ROW_W'(1), 1'b1);
    settle();
    // Upper bits of the write are dropped; the low two select the unused code.
    write_reg(CFG_MODE, {62'h3FFF_FFFF_FFFF_FFFD, MODE_ALIAS});
    send_map(63'h5555_5555_5555_5555, 1'b1);
  endtask

  // Index table: entries at both ends of the table, an index beyond the table
  // as the first element of a run (statistics still empty), and a last
  // element with an error that must still close the run.
  task automatic test_table_map();
    settle();
    write_reg(CFG_MODE, {62'h2969_4000_0000_0001, MODE_TABLE});
    send_load('0, ROW_MAX);
    send_load({ADDR_W{1'b1}}, '0);
    send_map(ROW_W'(TABLE_DEPTH_DEF), 1'b0);
    send_map('0, 1'b0);
    send_map(ROW_W'(TABLE_DEPTH_DEF - 1), 1'b0);
    send_map(ROW_MAX, 1'b1);
  endtask

  // Slice: zero stride from the top row, overflow above the row range, a
  // negative stride landing exactly on zero, the most negative stride, and
  // the largest positive stride just in range and just out of it.
  task automatic test_slice_map();
    settle();
    write_reg(CFG_MODE, {62'h2000_0000_0000_0000, MODE_SLICE});
    write_reg(CFG_START, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_STEP, 64'd0);
    send_map(ROW_MAX, 1'b0);
    settle();
    write_reg(CFG_STEP, 64'd1);
    send_map(ROW_W'(1), 1'b0);
    settle();
    write_reg(CFG_STEP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_map(ROW_MAX, 1'b0);
    settle();
    write_reg(CFG_STEP, 64'h8000_0000_0000_0000);
    send_map('0, 1'b0);
    send_map(ROW_W'(1), 1'b1);
    settle();
    write_reg(CFG_START, 64'd0);
    write_reg(CFG_STEP, 64'h7FFF_FFFF_FFFF_FFFF);
    send_map(ROW_W'(1), 1'b0);
    send_map(ROW_W'(2), 1'b1);
  endtask

  // One stretch of random traffic under one random configuration. Outer rows
  // are shaped by the form: small rows for the slice so that products often
  // stay in range, loaded indexes for the table so that reads hit written
  // entries, and rows past the table end for the index error.
  task automatic run_random_segment(input int n_items);
    logic [31:0]      hi;
    logic [31:0]      lo;
    logic [1:0]       mode;
    logic [ROW_W-1:0] b;
    settle();
    hi = $urandom;
    lo = $urandom;
    case ($urandom_range(19))
      0, 1, 2:                    mode = MODE_NONE;
      3, 4, 5, 6, 7, 8, 9:        mode = MODE_SLICE;
      10, 11, 12, 13, 14, 15, 16: mode = MODE_TABLE;
      default:                    mode = MODE_ALIAS;
    endcase
    write_reg(CFG_MODE, {hi, lo[31:2], mode});
    hi = $urandom;
    write_reg(CFG_START, {hi[0], pick_row()});
    write_reg(CFG_STEP, pick_step());
    repeat (n_items) begin
      if ($urandom_range(99) < 20) begin
        // Loads mostly go to a small corner of the table so that later reads
        // find them, and now and then anywhere in it.
        if ($urandom_range(3) == 0) send_load(ADDR_W'($urandom_range(4095)), pick_row());
        else send_load(ADDR_W'($urandom_range(63)), pick_row());
      end else begin
        case (mode)
          MODE_SLICE: begin
            case ($urandom_range(9))
              0:       b = pick_row();
              1:       b = '0;
              default: b = ROW_W'($urandom_range(300));
            endcase
          end
          MODE_TABLE: begin
            if (loaded_addrs.size() != 0 && $urandom_range(4) != 0) begin
              b = ROW_W'(loaded_addrs[$urandom_range(loaded_addrs.size() - 1)]);
            end else begin
              b = pick_row();
              if (b < TABLE_DEPTH_DEF) b = b + ROW_W'(TABLE_DEPTH_DEF);
            end
          end
          default: b = pick_row();
        endcase
        send_map(b, $urandom_range(7) == 0);
      end
    end
  endtask

  // Random traffic in four idling mixes: none, sender idle, receiver
  // stalling, and both at once. Each mix runs several configurations.
  task automatic test_random_traffic();
    int send_mix [4]  = '{0, 47, 0, 38};
    int stall_mix [4] = '{0, 0, 47, 38};
    logic [31:0] hi;
    logic [31:0] lo;
    // A write to the index with no register behind it must change nothing.
    settle();
    hi = $urandom;
    lo = $urandom;
    write_reg(CFG_UNUSED, {hi, lo});
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_mix[p];
      stall_pct     = stall_mix[p];
      repeat (4) run_random_segment(100 + $urandom_range(12));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_map();
    test_table_map();
    test_slice_map();
    test_random_traffic();
    settle();
    $display("Covered %0d transactions: %0d table loads, %0d row maps over %0d runs",
             loads_sent + maps_sent, loads_sent, maps_sent, runs_closed);
    $display("Map outcomes: %0d composed, %0d index past table, %0d slice overflow; %0d bad",
             ok_seen, idx_seen, ovf_seen, mismatches);
    if (mismatches == 0 && awaited_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
